@@ hw/rtl/tihm_pkg.sv @@
// Shared types and constants for the tag/index hash multimap.
// Field widths, opcode and status codes, payload structs, register map.
// No dependencies.
package tihm_pkg;

   localparam int OPCODE_W = 3;
   localparam int TARGET_W = 13;
   localparam int TAG_W    = 16;
   localparam int STATUS_W = 2;
   localparam int VALUE_W  = 16;
   localparam int TCOUNT_W = 13;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_TARGET_COUNT = 1'b0;
   localparam logic [TCOUNT_W-1:0] TARGET_COUNT_RESET = 13'd4096;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD     = 3'd0,
      OP_REMOVE  = 3'd1,
      OP_REBUILD = 3'd2,
      OP_HAS     = 3'd3,
      OP_FIRST   = 3'd4,
      OP_BEGIN   = 3'd5,
      OP_NEXT    = 3'd6,
      OP_LINEAR  = 3'd7
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK      = 2'd0,
      STS_IGNORED = 2'd1,
      STS_FULL    = 2'd2,
      STS_NOMATCH = 2'd3
   } status_type;

   typedef struct packed {
      status_type                 status;
      logic                       found;
      logic signed [VALUE_W-1:0]  value;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [TARGET_W-1:0] target;
      logic signed [TAG_W-1:0]    tag;
   } entry_type;

endpackage

@@ hw/rtl/tihm_if.sv @@
// Valid/ready channel interfaces for request and response items.
// Depends on tihm_pkg.
interface tihm_req_if import tihm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   opcode_type                 opcode;
   logic signed [TARGET_W-1:0] target;
   logic signed [TAG_W-1:0]    tag;

   modport source (output valid, opcode, target, tag, input ready);
   modport sink   (input valid, opcode, target, tag, output ready);
endinterface

interface tihm_rsp_if import tihm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   status_type                status;
   logic                      found;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, status, found, value, input ready);
   modport sink   (input valid, status, found, value, output ready);
endinterface

@@ hw/rtl/tihm_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies.
module tihm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end
endmodule

@@ hw/rtl/tihm_hash.sv @@
// Three-stage bucket hash: 32-bit pattern of a sign-extended tag modulo the
// bucket count, via reciprocal multiply and correction. Depends on tihm_pkg.
module tihm_hash import tihm_pkg::*; #(
   parameter int HASH_BUCKETS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [TAG_W-1:0]                in_tag,
   output logic                            out_valid,
   output logic [$clog2(HASH_BUCKETS)-1:0] out_bucket
);
   localparam int BW  = $clog2(HASH_BUCKETS);
   localparam int BW1 = BW + 1;
   localparam logic [31:0]  RECIP = 32'((64'd1 << 32) / HASH_BUCKETS);
   localparam logic [BW1-1:0] NEG_OFS =
      BW1'(((64'd1 << 32) - (64'd1 << 16)) % HASH_BUCKETS);
   localparam logic [BW1-1:0] HB = BW1'(HASH_BUCKETS);

   logic [47:0]      prod;
   logic [31:0]      qh;
   logic [31:0]      rem_full;
   logic [BW1-1:0]   r3;
   logic [BW1-1:0]   s3;
   logic [TAG_W-1:0] q1_ff, u1_ff;
   logic             neg1_ff, neg2_ff;
   logic [BW1-1:0]   r2_ff;
   logic [BW-1:0]    bucket_ff;
   logic             v1_ff, v2_ff, v3_ff;

   // quotient estimate, low by at most one
   assign prod     = 48'(in_tag) * 48'(RECIP);
   assign qh       = 32'(q1_ff) * 32'(HASH_BUCKETS);
   assign rem_full = 32'(u1_ff) - qh;
   // fold in the upper half of the 32-bit pattern for negative tags
   assign r3 = (r2_ff >= HB) ? r2_ff - HB : r2_ff;
   assign s3 = r3 + (neg2_ff ? NEG_OFS : '0);

   always_ff @(posedge clock) begin
      q1_ff     <= prod[47:32];
      u1_ff     <= in_tag;
      neg1_ff   <= in_tag[TAG_W-1];
      r2_ff     <= BW1'(rem_full);
      neg2_ff   <= neg1_ff;
      bucket_ff <= BW'((s3 >= HB) ? s3 - HB : s3);
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid  = v3_ff;
   assign out_bucket = bucket_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##3 out_valid)
      else $error("hash result missing three cycles after request");
   a_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (int'(out_bucket) < HASH_BUCKETS))
      else $error("bucket index out of range");
endmodule

@@ hw/rtl/tihm_ctrl.sv @@
// Sequencer of the multimap: owns the entry, chain, start and bucket RAMs
// and walks them from a single state machine. Depends on tihm_pkg, tihm_if,
// tihm_ram and tihm_hash.
module tihm_ctrl import tihm_pkg::*; #(
   parameter int MAX_ENTRIES  = 4096,
   parameter int MAX_TARGETS  = 4096,
   parameter int HASH_BUCKETS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [TCOUNT_W-1:0] target_count,
   tihm_req_if.sink            req,
   input  logic                res_slot_free,
   output logic                res_load,
   output rsp_payload_type     res
);
   localparam int EW   = $clog2(MAX_ENTRIES);
   localparam int PW   = EW + 1;
   localparam int CW   = EW + 1;
   localparam int TW   = $clog2(MAX_TARGETS);
   localparam int IW   = TW + 1;
   localparam int BW   = $clog2(HASH_BUCKETS);
   localparam int SPW  = (PW > TW + 2) ? PW : TW + 2;
   localparam int CLRD = (MAX_TARGETS > HASH_BUCKETS) ? MAX_TARGETS : HASH_BUCKETS;
   localparam int CLRW = $clog2(CLRD);
   localparam int EBW  = $bits(entry_type);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_SRD, ST_SCHK, ST_IRD, ST_ICHK, ST_CHAIN, ST_ADD_WR,
      ST_ZSCAN, ST_LSCAN, ST_RB_CLR, ST_RB_NEXT, ST_RB_RD, ST_RB_CHK, ST_RB_HASH,
      ST_RB_LINK, ST_BS_HASH, ST_BS_HEAD, ST_DONE
   } state_type;

   state_type                  state_ff;
   opcode_type                 op_ff;
   logic signed [TARGET_W-1:0] t_ff;
   logic signed [TAG_W-1:0]    tag_ff;
   logic [CW-1:0]              k_ff;
   logic [CW-1:0]              count_ff;
   logic signed [PW-1:0]       ptr_ff;
   logic [IW-1:0]              i_ff;
   logic [CLRW-1:0]            clr_ff;
   logic [BW-1:0]              bkt_ff;
   logic                       sneg_ff;
   logic signed [SPW-1:0]      spos_ff;
   logic signed [TAG_W-1:0]    stag_ff;
   rsp_payload_type            res_ff;

   logic                       t_ok;
   logic signed [TARGET_W:0]   lin_raw;
   logic signed [TARGET_W:0]   lin_start;
   logic [IW-1:0]              lim;
   logic                       add_ok;

   logic                       info_we;
   logic [EW-1:0]              info_wa;
   logic [EBW-1:0]             info_wd;
   logic [EW-1:0]              info_ra;
   entry_type                  e;
   logic                       next_we;
   logic [EW-1:0]              next_wa;
   logic [PW-1:0]              next_wd;
   logic signed [PW-1:0]       next_rd;
   logic                       start_we;
   logic [TW-1:0]              start_wa;
   logic [PW-1:0]              start_wd;
   logic [TW-1:0]              start_ra;
   logic signed [PW-1:0]       start_rd;
   logic                       bkt_we;
   logic [BW-1:0]              bkt_wa;
   logic [PW-1:0]              bkt_wd;
   logic signed [PW-1:0]       bkt_rd;
   logic                       hash_in_valid;
   logic [TAG_W-1:0]           hash_in_tag;
   logic                       hash_valid;
   logic [BW-1:0]              hash_bkt;

   assign t_ok      = !req.target[TARGET_W-1] && (int'(req.target) < MAX_TARGETS);
   assign lin_raw   = (TARGET_W+1)'(req.target) + (TARGET_W+1)'(1);
   assign lin_start = lin_raw[TARGET_W] ? '0 : lin_raw;
   assign lim       = (int'(target_count) > MAX_TARGETS) ? IW'(MAX_TARGETS)
                                                        : IW'(target_count);
   assign add_ok    = count_ff < CW'(MAX_ENTRIES);

   // memory port steering: each state sets the write enables, addresses and data
   always_comb begin
      info_we  = 1'b0;
      info_wa  = k_ff[EW-1:0];
      info_wd  = '1;
      info_ra  = (state_ff == ST_CHAIN) ? ptr_ff[EW-1:0] : k_ff[EW-1:0];
      next_we  = 1'b0;
      next_wa  = k_ff[EW-1:0];
      next_wd  = bkt_rd;
      start_we = 1'b0;
      start_wa = TW'(clr_ff);
      start_wd = '1;
      start_ra = (op_ff == OP_NEXT || op_ff == OP_LINEAR) ? i_ff[TW-1:0]
                                                          : TW'($unsigned(t_ff));
      bkt_we   = 1'b0;
      bkt_wa   = BW'(clr_ff);
      bkt_wd   = '1;
      unique case (state_ff)
         ST_CLEAR: begin
            start_we = int'(clr_ff) < MAX_TARGETS;
            bkt_we   = int'(clr_ff) < HASH_BUCKETS;
         end
         ST_RB_CLR: begin
            bkt_we = 1'b1;
         end
         ST_ICHK: begin
            // drop the entry of a removed target
            info_we = (op_ff == OP_REMOVE) && (e.target == t_ff);
         end
         ST_ADD_WR: begin
            info_we  = add_ok;
            info_wa  = count_ff[EW-1:0];
            info_wd  = {t_ff, tag_ff};
            next_we  = add_ok;
            next_wa  = count_ff[EW-1:0];
            next_wd  = '1;
            start_we = add_ok && sneg_ff;
            start_wa = TW'($unsigned(t_ff));
            start_wd = count_ff;
         end
         ST_RB_LINK: begin
            next_we = 1'b1;
            bkt_we  = 1'b1;
            bkt_wa  = bkt_ff;
            bkt_wd  = PW'(k_ff);
         end
         default: begin
         end
      endcase
   end

   assign hash_in_valid = (state_ff == ST_IDLE && req.valid && req.opcode == OP_BEGIN
                           && req.tag != '0)
                        || (state_ff == ST_RB_CHK && !e.target[TARGET_W-1]);
   assign hash_in_tag   = (state_ff == ST_IDLE) ? req.tag : e.tag;

   tihm_ram #(.WIDTH(EBW), .DEPTH(MAX_ENTRIES)) u_info_ram (
      .clock(clock), .wr_en(info_we), .wr_addr(info_wa), .wr_data(info_wd),
      .rd_addr(info_ra), .rd_data(e)
   );
   tihm_ram #(.WIDTH(PW), .DEPTH(MAX_ENTRIES)) u_next_ram (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(info_ra), .rd_data(next_rd)
   );
   tihm_ram #(.WIDTH(PW), .DEPTH(MAX_TARGETS)) u_start_ram (
      .clock(clock), .wr_en(start_we), .wr_addr(start_wa), .wr_data(start_wd),
      .rd_addr(start_ra), .rd_data(start_rd)
   );
   tihm_ram #(.WIDTH(PW), .DEPTH(HASH_BUCKETS)) u_bucket_ram (
      .clock(clock), .wr_en(bkt_we), .wr_addr(bkt_wa), .wr_data(bkt_wd),
      .rd_addr(hash_bkt), .rd_data(bkt_rd)
   );
   tihm_hash #(.HASH_BUCKETS(HASH_BUCKETS)) u_hash (
      .clock(clock), .reset(reset), .in_valid(hash_in_valid), .in_tag(hash_in_tag),
      .out_valid(hash_valid), .out_bucket(hash_bkt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
         spos_ff  <= '1;
         stag_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CLRW'(CLRD - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: if (req.valid) begin
               op_ff        <= req.opcode;
               t_ff         <= req.target;
               tag_ff       <= req.tag;
               res_ff.status <= STS_OK;
               res_ff.found  <= 1'b0;
               res_ff.value  <= '0;
               unique case (req.opcode)
                  OP_ADD: begin
                     if (req.tag == '0 || !t_ok) begin
                        res_ff.status <= STS_IGNORED;
                        state_ff      <= ST_DONE;
                     end else begin
                        state_ff <= ST_SRD;
                     end
                  end
                  OP_REMOVE: state_ff <= t_ok ? ST_SRD : ST_DONE;
                  OP_HAS, OP_FIRST: begin
                     if (t_ok) begin
                        state_ff <= ST_SRD;
                     end else begin
                        res_ff.status <= STS_NOMATCH;
                        state_ff      <= ST_DONE;
                     end
                  end
                  OP_REBUILD: begin
                     clr_ff   <= '0;
                     state_ff <= ST_RB_CLR;
                  end
                  OP_BEGIN: begin
                     stag_ff <= req.tag;
                     if (req.tag == '0) begin
                        spos_ff  <= '0;
                        state_ff <= ST_DONE;
                     end else begin
                        state_ff <= ST_BS_HASH;
                     end
                  end
                  OP_NEXT: begin
                     if (stag_ff != '0) begin
                        ptr_ff   <= PW'(spos_ff);
                        state_ff <= ST_CHAIN;
                     end else if (spos_ff[SPW-1]) begin
                        spos_ff       <= '0;
                        res_ff.status <= STS_NOMATCH;
                        state_ff      <= ST_DONE;
                     end else begin
                        i_ff     <= IW'(spos_ff);
                        state_ff <= ST_ZSCAN;
                     end
                  end
                  OP_LINEAR: begin
                     res_ff.status <= STS_NOMATCH;
                     if (int'(lin_start) >= int'(lim)) begin
                        state_ff <= ST_DONE;
                     end else begin
                        i_ff     <= IW'(lin_start);
                        state_ff <= ST_LSCAN;
                     end
                  end
               endcase
            end
            ST_SRD: state_ff <= ST_SCHK;
            ST_SCHK: begin
               unique case (op_ff)
                  OP_ADD: begin
                     sneg_ff <= start_rd[PW-1];
                     k_ff    <= CW'(start_rd);
                     state_ff <= start_rd[PW-1] ? ST_ADD_WR : ST_IRD;
                  end
                  OP_REMOVE: begin
                     k_ff     <= CW'(start_rd);
                     state_ff <= start_rd[PW-1] ? ST_DONE : ST_IRD;
                  end
                  OP_HAS: begin
                     k_ff <= CW'(start_rd);
                     if (start_rd[PW-1]) begin
                        res_ff.status <= STS_NOMATCH;
                        state_ff      <= ST_DONE;
                     end else begin
                        state_ff <= ST_IRD;
                     end
                  end
                  OP_FIRST: begin
                     k_ff <= CW'(start_rd);
                     if (!start_rd[PW-1] && CW'(start_rd) < count_ff) begin
                        state_ff <= ST_IRD;
                     end else begin
                        res_ff.status <= STS_NOMATCH;
                        state_ff      <= ST_DONE;
                     end
                  end
                  OP_NEXT: begin
                     // zero-tag search: stop at the first target without a start
                     if (!start_rd[PW-1]) begin
                        i_ff     <= i_ff + 1'b1;
                        state_ff <= ST_ZSCAN;
                     end else begin
                        res_ff.found <= 1'b1;
                        res_ff.value <= VALUE_W'(i_ff);
                        spos_ff      <= SPW'(i_ff) + 1'b1;
                        state_ff     <= ST_DONE;
                     end
                  end
                  OP_LINEAR: begin
                     k_ff <= CW'(start_rd);
                     if (start_rd[PW-1]) begin
                        i_ff     <= i_ff + 1'b1;
                        state_ff <= ST_LSCAN;
                     end else begin
                        state_ff <= ST_IRD;
                     end
                  end
                  default: state_ff <= ST_DONE;
               endcase
            end
            ST_IRD: begin
               if (k_ff >= count_ff) begin
                  priority case (op_ff)
                     OP_ADD: state_ff <= ST_ADD_WR;
                     OP_HAS: begin
                        res_ff.status <= STS_NOMATCH;
                        state_ff      <= ST_DONE;
                     end
                     OP_LINEAR: begin
                        i_ff     <= i_ff + 1'b1;
                        state_ff <= ST_LSCAN;
                     end
                     default: state_ff <= ST_DONE;
                  endcase
               end else begin
                  state_ff <= ST_ICHK;
               end
            end
            ST_ICHK: begin
               unique case (op_ff)
                  OP_ADD: begin
                     if (e.tag == tag_ff) begin
                        res_ff.status <= STS_IGNORED;
                        state_ff      <= ST_DONE;
                     end else begin
                        k_ff     <= k_ff + 1'b1;
                        state_ff <= ST_IRD;
                     end
                  end
                  OP_REMOVE: begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= (e.target == t_ff) ? ST_IRD : ST_DONE;
                  end
                  OP_HAS: begin
                     if (e.target != t_ff) begin
                        res_ff.status <= STS_NOMATCH;
                        state_ff      <= ST_DONE;
                     end else if (e.tag == tag_ff) begin
                        res_ff.found <= 1'b1;
                        state_ff     <= ST_DONE;
                     end else begin
                        k_ff     <= k_ff + 1'b1;
                        state_ff <= ST_IRD;
                     end
                  end
                  OP_FIRST: begin
                     res_ff.found <= 1'b1;
                     res_ff.value <= e.tag;
                     state_ff     <= ST_DONE;
                  end
                  OP_LINEAR: begin
                     if (int'(e.target) != int'(i_ff)) begin
                        i_ff     <= i_ff + 1'b1;
                        state_ff <= ST_LSCAN;
                     end else if (e.tag == tag_ff) begin
                        res_ff.status <= STS_OK;
                        res_ff.found  <= 1'b1;
                        res_ff.value  <= VALUE_W'(i_ff);
                        state_ff      <= ST_DONE;
                     end else begin
                        k_ff     <= k_ff + 1'b1;
                        state_ff <= ST_IRD;
                     end
                  end
                  OP_NEXT: begin
                     // hash chain walk: skip entries of other tags
                     if (e.tag != stag_ff) begin
                        ptr_ff   <= next_rd;
                        state_ff <= ST_CHAIN;
                     end else begin
                        spos_ff <= SPW'(next_rd);
                        if (!e.target[TARGET_W-1]) begin
                           res_ff.found <= 1'b1;
                           res_ff.value <= VALUE_W'(e.target);
                        end else begin
                           res_ff.status <= STS_NOMATCH;
                        end
                        state_ff <= ST_DONE;
                     end
                  end
                  default: state_ff <= ST_DONE;
               endcase
            end
            ST_CHAIN: begin
               if (ptr_ff[PW-1] || CW'(ptr_ff) >= count_ff) begin
                  spos_ff       <= '1;
                  res_ff.status <= STS_NOMATCH;
                  state_ff      <= ST_DONE;
               end else begin
                  state_ff <= ST_ICHK;
               end
            end
            ST_ADD_WR: begin
               if (add_ok) begin
                  count_ff <= count_ff + 1'b1;
               end else begin
                  res_ff.status <= STS_FULL;
               end
               state_ff <= ST_DONE;
            end
            ST_ZSCAN: begin
               if (i_ff >= lim) begin
                  spos_ff       <= SPW'(i_ff);
                  res_ff.status <= STS_NOMATCH;
                  state_ff      <= ST_DONE;
               end else begin
                  state_ff <= ST_SRD;
               end
            end
            ST_LSCAN: state_ff <= (i_ff >= lim) ? ST_DONE : ST_SRD;
            ST_RB_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CLRW'(HASH_BUCKETS - 1)) begin
                  k_ff     <= count_ff;
                  state_ff <= ST_RB_NEXT;
               end
            end
            ST_RB_NEXT: begin
               if (k_ff == '0) begin
                  state_ff <= ST_DONE;
               end else begin
                  k_ff     <= k_ff - 1'b1;
                  state_ff <= ST_RB_RD;
               end
            end
            ST_RB_RD: state_ff <= ST_RB_CHK;
            ST_RB_CHK: state_ff <= e.target[TARGET_W-1] ? ST_RB_NEXT : ST_RB_HASH;
            ST_RB_HASH: if (hash_valid) begin
               bkt_ff   <= hash_bkt;
               state_ff <= ST_RB_LINK;
            end
            ST_RB_LINK: state_ff <= ST_RB_NEXT;
            ST_BS_HASH: if (hash_valid) state_ff <= ST_BS_HEAD;
            ST_BS_HEAD: begin
               spos_ff  <= SPW'(bkt_rd);
               state_ff <= ST_DONE;
            end
            ST_DONE: if (res_slot_free) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign res_load  = (state_ff == ST_DONE) && res_slot_free;
   assign res       = res_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count beyond table size");
   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff >= $past(count_ff)))
      else $error("entry count went down");
   a_add_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD_WR && add_ok) |=> (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("append did not advance entry count");
endmodule

@@ hw/rtl/tag_index_hash_multimap.sv @@
// Top level of the tag/index hash multimap: register port, result register.
// Depends on tihm_pkg, tihm_if and tihm_ctrl.
//
// Usage: send one request item (opcode, target, tag) on req_ch; each item
// gives exactly one result item (status, found, value) on rsp_ch, in order.
// Both channels are valid/ready; an item moves when valid and ready are high
// at a clock edge. The register target_count (byte address 0) bounds the
// zero-tag and linear scans; write it only while the block is idle.
// After reset the block runs a clearing pass over every entry of the start
// and bucket tables with req_ch.ready low; register writes are taken during
// that time.
// An op decided at acceptance goes straight to the result; other ops read
// target starts and visit entries one at a time; add scans from the target's
// start to the table end; begin search of a nonzero tag hashes the tag and
// reads the bucket head; rebuild clears the buckets, then hashes and links
// each live entry; a next search with a nonzero tag walks the hash chain.
// Each table has one read port with a registered read.
// A finished result sits in the output register; a new item is accepted
// while it waits, and the next result holds until rsp_ch.ready drains it.
module tag_index_hash_multimap import tihm_pkg::*; #(
   parameter int MAX_ENTRIES  = 4096,
   parameter int MAX_TARGETS  = 4096,
   parameter int HASH_BUCKETS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   tihm_req_if.sink              req_ch,
   tihm_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);
   logic [TCOUNT_W-1:0] target_count_ff;
   logic                rsp_valid_ff;
   rsp_payload_type     rsp_ff;
   logic                res_slot_free;
   logic                res_load;
   rsp_payload_type     res;
   logic                csr_hit;

   // register decode: only paddr[2] is decoded; target_count is the word at byte address 0
   assign csr_hit = (paddr[CSR_ADDR_W-1] == CSR_IDX_TARGET_COUNT);
   assign pready  = 1'b1;
   assign prdata  = csr_hit ? CSR_DATA_W'(target_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_count_ff <= TARGET_COUNT_RESET;
      end else if (psel && penable && pwrite && csr_hit) begin
         target_count_ff <= pwdata[TCOUNT_W-1:0];
      end
   end

   // result register: load when empty or draining, hold while stalled
   assign res_slot_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_ff.status;
   assign rsp_ch.found  = rsp_ff.found;
   assign rsp_ch.value  = rsp_ff.value;

   tihm_ctrl #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .MAX_TARGETS(MAX_TARGETS),
      .HASH_BUCKETS(HASH_BUCKETS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .target_count(target_count_ff),
      .req(req_ch),
      .res_slot_free(res_slot_free),
      .res_load(res_load),
      .res(res)
   );
endmodule
